### rtl/core/itc_pkg.sv
package itc_pkg;

  // item kind carried in the low bits of the slave tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // access field of a command byte
  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LSB   = 2'd1,
    ACC_MSB   = 2'd2,
    ACC_BOTH  = 2'd3
  } acc_t;

  localparam logic [1:0] CMD_PORT = 2'd3;

  localparam logic [2:0] OPM_RATE   = 3'd2;
  localparam logic [2:0] OPM_SQUARE = 3'd3;
  localparam logic [2:0] OPM_FOLD   = 3'd6;
  localparam logic [2:0] OPM_STEP   = 3'd4;

  localparam int IN_TDATA_W   = 8;
  localparam int IN_TUSER_W   = 4;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_TUSER_W  = 1;
  localparam int PULSE_W      = 3;

endpackage

### rtl/core/interval_timer_counters.sv
// channel  | group   | tdata                                  | tuser
// ---------+---------+----------------------------------------+---------------------------
// items in | s_axis  | [7:0] write_data                       | [1:0] kind, [3:2] port
// results  | m_axis  | [7:0] read_data, [10:8] terminal_pulses | [0] read_valid
//
// one result per item, offered the cycle after accept; an item per cycle unless stalled
// the counter state and the result register update together at the accept edge
// s_axis_tready drops only while a result sits unread in the output register
// rst (synchronous) clears all counters, puts every counter in lsb-then-msb access, idle
module interval_timer_counters
  import itc_pkg::*;
#(
  parameter int NUM_COUNTERS = 3,
  parameter int COUNT_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] write_data
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] kind, [3:2] port
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] read_data, [10:8] terminal_pulses
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] read_valid
);

  logic [COUNT_BITS-1:0] count_value   [NUM_COUNTERS];
  logic [COUNT_BITS-1:0] reload_value  [NUM_COUNTERS];
  logic [COUNT_BITS-1:0] latched_value [NUM_COUNTERS];
  logic                  latch_held    [NUM_COUNTERS];
  acc_t                  access_kind   [NUM_COUNTERS];
  logic [2:0]            operating_mode[NUM_COUNTERS];
  logic                  write_high    [NUM_COUNTERS];
  logic                  read_high     [NUM_COUNTERS];
  logic                  counting      [NUM_COUNTERS];

  logic [COUNT_BITS-1:0] count_value_next   [NUM_COUNTERS];
  logic [COUNT_BITS-1:0] reload_value_next  [NUM_COUNTERS];
  logic [COUNT_BITS-1:0] latched_value_next [NUM_COUNTERS];
  logic                  latch_held_next    [NUM_COUNTERS];
  acc_t                  access_kind_next   [NUM_COUNTERS];
  logic [2:0]            operating_mode_next[NUM_COUNTERS];
  logic                  write_high_next    [NUM_COUNTERS];
  logic                  read_high_next     [NUM_COUNTERS];
  logic                  counting_next      [NUM_COUNTERS];

  logic       in_fire;
  kind_t      kind;
  logic [1:0] port;
  logic [7:0] wbyte;
  logic [1:0] cmd_sel;
  acc_t       cmd_acc;
  logic [2:0] cmd_mode;

  logic [7:0]         read_data_next;
  logic               read_valid_next;
  logic [PULSE_W-1:0] pulses_next;

  logic [7:0]         read_data;
  logic               read_valid;
  logic [PULSE_W-1:0] pulses;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign kind     = kind_t'(s_axis_tuser[1:0]);
  assign port     = s_axis_tuser[3:2];
  assign wbyte    = s_axis_tdata[7:0];
  assign cmd_sel  = wbyte[7:6];
  assign cmd_acc  = acc_t'(wbyte[5:4]);
  assign cmd_mode = (wbyte[3:1] >= OPM_FOLD) ? (wbyte[3:1] - OPM_STEP) : wbyte[3:1];

  always_comb begin
    logic [15:0] rel16;
    logic [15:0] src16;
    read_data_next  = '0;
    read_valid_next = 1'b0;
    pulses_next     = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      count_value_next[i]    = count_value[i];
      reload_value_next[i]   = reload_value[i];
      latched_value_next[i]  = latched_value[i];
      latch_held_next[i]     = latch_held[i];
      access_kind_next[i]    = access_kind[i];
      operating_mode_next[i] = operating_mode[i];
      write_high_next[i]     = write_high[i];
      read_high_next[i]      = read_high[i];
      counting_next[i]       = counting[i];
      rel16 = 16'(reload_value[i]);
      src16 = 16'(latch_held[i] ? latched_value[i] : count_value[i]);

      unique case (kind)
        KIND_TICK: begin
          if (counting[i]) begin
            // terminal count is reached from a count of one in every mode
            if (count_value[i] == COUNT_BITS'(1)) begin
              pulses_next[i] = 1'b1;
            end
            if ((operating_mode[i] == OPM_RATE || operating_mode[i] == OPM_SQUARE) &&
                count_value[i] == COUNT_BITS'(1)) begin
              count_value_next[i] = reload_value[i];
            end else begin
              count_value_next[i] = count_value[i] - COUNT_BITS'(1);
            end
          end
        end
        KIND_WRITE: begin
          if (port == CMD_PORT) begin
            if (cmd_sel == 2'(i)) begin
              if (cmd_acc == ACC_LATCH) begin
                if (!latch_held[i]) begin
                  latched_value_next[i] = count_value[i];
                  latch_held_next[i]    = 1'b1;
                end
              end else begin
                access_kind_next[i]    = cmd_acc;
                operating_mode_next[i] = cmd_mode;
                latch_held_next[i]     = 1'b0;
                write_high_next[i]     = 1'b0;
                read_high_next[i]      = 1'b0;
                counting_next[i]       = 1'b0;
              end
            end
          end else if (port == 2'(i)) begin
            unique case (access_kind[i])
              ACC_LSB: begin
                reload_value_next[i] = COUNT_BITS'(wbyte);
                count_value_next[i]  = COUNT_BITS'(wbyte);
                counting_next[i]     = 1'b1;
              end
              ACC_MSB: begin
                reload_value_next[i] = COUNT_BITS'({wbyte, 8'h00});
                count_value_next[i]  = COUNT_BITS'({wbyte, 8'h00});
                counting_next[i]     = 1'b1;
              end
              default: begin
                if (!write_high[i]) begin
                  reload_value_next[i] = COUNT_BITS'({rel16[15:8], wbyte});
                  write_high_next[i]   = 1'b1;
                end else begin
                  reload_value_next[i] = COUNT_BITS'({wbyte, rel16[7:0]});
                  count_value_next[i]  = COUNT_BITS'({wbyte, rel16[7:0]});
                  write_high_next[i]   = 1'b0;
                  counting_next[i]     = 1'b1;
                end
              end
            endcase
          end
        end
        KIND_READ: begin
          if (port == 2'(i)) begin
            read_valid_next = 1'b1;
            unique case (access_kind[i])
              ACC_LSB: begin
                read_data_next     = src16[7:0];
                latch_held_next[i] = 1'b0;
              end
              ACC_MSB: begin
                read_data_next     = src16[15:8];
                latch_held_next[i] = 1'b0;
              end
              default: begin
                if (!read_high[i]) begin
                  read_data_next    = src16[7:0];
                  read_high_next[i] = 1'b1;
                end else begin
                  read_data_next     = src16[15:8];
                  read_high_next[i]  = 1'b0;
                  latch_held_next[i] = 1'b0;
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        count_value[i]    <= '0;
        reload_value[i]   <= '0;
        latched_value[i]  <= '0;
        latch_held[i]     <= 1'b0;
        access_kind[i]    <= ACC_BOTH;
        operating_mode[i] <= '0;
        write_high[i]     <= 1'b0;
        read_high[i]      <= 1'b0;
        counting[i]       <= 1'b0;
      end
    end else if (in_fire) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        count_value[i]    <= count_value_next[i];
        reload_value[i]   <= reload_value_next[i];
        latched_value[i]  <= latched_value_next[i];
        latch_held[i]     <= latch_held_next[i];
        access_kind[i]    <= access_kind_next[i];
        operating_mode[i] <= operating_mode_next[i];
        write_high[i]     <= write_high_next[i];
        read_high[i]      <= read_high_next[i];
        counting[i]       <= counting_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data  <= read_data_next;
      read_valid <= read_valid_next;
      pulses     <= pulses_next;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - 8 - PULSE_W){1'b0}}, pulses, read_data};
  assign m_axis_tuser = read_valid;

endmodule

### rtl/core/itc_checker.sv
module itc_checker
  import itc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // every accepted transaction produces a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_axis_tvalid)
    else $error("accepted transaction gave no result");

  // only reads return a byte
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tuser[1:0] != KIND_READ |=>
      m_axis_tuser[0] == 1'b0 && m_axis_tdata[7:0] == 8'h00)
    else $error("read byte on a non-read transaction");

  // only ticks raise terminal pulses
  a_tick_only: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tuser[1:0] != KIND_TICK |=> m_axis_tdata[10:8] == 3'b000)
    else $error("terminal pulse on a non-tick transaction");

endmodule

bind interval_timer_counters itc_checker u_itc_checker (.*);

### tb/interval_timer_counters_checker.sv
`timescale 1ns / 100ps

module interval_timer_counters_checker
  import itc_pkg::*;
#(
  parameter int NUM_COUNTERS = 3,
  parameter int COUNT_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] write_data
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] kind, [3:2] port
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] read_data, [10:8] terminal_pulses
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] read_valid
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    logic [7:0]         rdata;
    logic               rvalid;
    logic [PULSE_W-1:0] pulses;
  } timer_result_t;

  localparam logic [15:0] CNT_MASK = 16'((32'd1 << COUNT_BITS) - 32'd1);

  // per-counter state of the predicted timer
  logic [15:0] cnt     [3];
  logic [15:0] reload  [3];
  logic [15:0] latched [3];
  logic        held    [3];
  acc_t        access  [3];
  logic [2:0]  opm     [3];
  logic        wr_hi   [3];
  logic        rd_hi   [3];
  logic        running [3];

  timer_result_t result_q[$];
  timer_result_t got, want;
  int            fail_n;

  function automatic void start_count(int c, logic [15:0] v);
    reload[c]  = v & CNT_MASK;
    cnt[c]     = reload[c];
    running[c] = 1'b1;
  endfunction

  function automatic timer_result_t step_timer(kind_t k, logic [1:0] p, logic [7:0] d);
    timer_result_t r;
    int            c;
    int            sel;
    acc_t          a;
    logic [2:0]    m;
    logic [15:0]   src;
    r = '0;
    c = int'(p);
    case (k)
      KIND_TICK: begin
        for (int i = 0; i < NUM_COUNTERS && i < 3; i++) begin
          if (running[i]) begin
            if (opm[i] == OPM_RATE || opm[i] == OPM_SQUARE) begin
              // periodic modes reload at one, so a zero reload runs the full period
              if (cnt[i] == 16'd1) begin
                cnt[i]      = reload[i] & CNT_MASK;
                r.pulses[i] = 1'b1;
              end else begin
                cnt[i] = (cnt[i] - 16'd1) & CNT_MASK;
              end
            end else begin
              cnt[i] = (cnt[i] - 16'd1) & CNT_MASK;
              if (cnt[i] == 16'd0) r.pulses[i] = 1'b1;
            end
          end
        end
      end
      KIND_WRITE: begin
        if (p == CMD_PORT) begin
          sel = int'(d[7:6]);
          a   = acc_t'(d[5:4]);
          m   = d[3:1];
          // read-back selector and absent counters fall through here
          if (sel < NUM_COUNTERS && sel < 3) begin
            if (a == ACC_LATCH) begin
              if (!held[sel]) begin
                latched[sel] = cnt[sel] & CNT_MASK;
                held[sel]    = 1'b1;
              end
            end else begin
              if (m >= OPM_FOLD) m = m - OPM_STEP;
              access[sel]  = a;
              opm[sel]     = m;
              held[sel]    = 1'b0;
              wr_hi[sel]   = 1'b0;
              rd_hi[sel]   = 1'b0;
              running[sel] = 1'b0;
            end
          end
        end else if (c < NUM_COUNTERS) begin
          case (access[c])
            ACC_LSB: start_count(c, {8'h00, d});
            ACC_MSB: start_count(c, {d, 8'h00});
            default: begin
              if (!wr_hi[c]) begin
                reload[c][7:0] = d;
                wr_hi[c]       = 1'b1;
              end else begin
                reload[c][15:8] = d;
                wr_hi[c]        = 1'b0;
                start_count(c, reload[c]);
              end
            end
          endcase
        end
      end
      KIND_READ: begin
        if (p != CMD_PORT && c < NUM_COUNTERS) begin
          src      = (held[c] ? latched[c] : cnt[c]) & CNT_MASK;
          r.rvalid = 1'b1;
          case (access[c])
            ACC_LSB: begin
              r.rdata = src[7:0];
              held[c] = 1'b0;
            end
            ACC_MSB: begin
              r.rdata = src[15:8];
              held[c] = 1'b0;
            end
            default: begin
              if (!rd_hi[c]) begin
                r.rdata  = src[7:0];
                rd_hi[c] = 1'b1;
              end else begin
                r.rdata  = src[15:8];
                rd_hi[c] = 1'b0;
                held[c]  = 1'b0;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cnt[i]     = '0;
        reload[i]  = '0;
        latched[i] = '0;
        held[i]    = 1'b0;
        access[i]  = ACC_BOTH;
        opm[i]     = '0;
        wr_hi[i]   = 1'b0;
        rd_hi[i]   = 1'b0;
        running[i] = 1'b0;
      end
      result_q.delete();
      fail_n = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(step_timer(kind_t'(s_axis_tuser[1:0]), s_axis_tuser[3:2],
                                      s_axis_tdata[7:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.rdata  = m_axis_tdata[7:0];
        got.pulses = m_axis_tdata[10:8];
        got.rvalid = m_axis_tuser[0];
        if (result_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: result with no transaction pending: read_data %02h valid %b pulses %03b",
                     $realtime, got.rdata, got.rvalid, got.pulses);
        end else begin
          want = result_q.pop_front();
          if (got.rdata !== want.rdata || got.rvalid !== want.rvalid ||
              got.pulses !== want.pulses) begin
            fail_n++;
            if (fail_n <= 10)
              $display("%0t: mismatch read_data exp %02h got %02h, read_valid exp %b got %b, %s",
                       $realtime, want.rdata, got.rdata, want.rvalid, got.rvalid,
                       $sformatf("terminal_pulses exp %03b got %03b", want.pulses, got.pulses));
          end
        end
      end
    end
    mismatches  <= fail_n;
    outstanding <= result_q.size();
  end

endmodule

### tb/interval_timer_counters_tb.sv
`timescale 1ns / 100ps

module interval_timer_counters_tb;
  import itc_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] write_data
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // [1:0] kind, [3:2] port
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] read_data, [10:8] terminal_pulses
  logic [OUT_TUSER_W-1:0] m_axis_tuser;         // [0] read_valid

  int   fail_count;
  int   pending;
  int   sent = 0;
  int   stuck = 0;
  logic quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interval_timer_counters u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  interval_timer_counters_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (fail_count),
    .outstanding   (pending)
  );

  // result side stalls at random except during the quiet stretch
  always @(negedge clk) begin
    if (!rst) m_axis_tready <= quiet || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else if (stuck + 1 >= STALL_LIMIT) begin
      $display("interval_timer_counters_tb NOT OK");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic send_item(input kind_t k, input logic [1:0] p, input logic [7:0] d);
    while (!quiet && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {p, k};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_item(KIND_TICK, 2'($urandom_range(3)), 8'($urandom));
  endtask

  task automatic read_counter(input logic [1:0] c);
    send_item(KIND_READ, c, 8'($urandom));
  endtask

  task automatic latch_counter(input logic [1:0] c);
    send_item(KIND_WRITE, CMD_PORT, {c, ACC_LATCH, 4'($urandom)});
  endtask

  // command byte then the reload bytes the chosen access takes
  task automatic program_counter(input logic [1:0] c, input acc_t a, input logic [2:0] m,
                                 input logic [15:0] v);
    send_item(KIND_WRITE, CMD_PORT, {c, a, m, 1'($urandom_range(1))});
    case (a)
      ACC_LSB: send_item(KIND_WRITE, c, v[7:0]);
      ACC_MSB: send_item(KIND_WRITE, c, v[15:8]);
      default: begin
        send_item(KIND_WRITE, c, v[7:0]);
        send_item(KIND_WRITE, c, v[15:8]);
      end
    endcase
  endtask

  initial begin : stimulus
    logic [1:0]  c;
    acc_t        a;
    logic [2:0]  m;
    logic [15:0] v;
    int          pick;
    int          next_drain;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle counters after reset, command port read, tick with nothing running
    read_counter(2'd0);
    read_counter(2'd0);
    send_item(KIND_READ, CMD_PORT, 8'h00);
    send_item(KIND_TICK, 2'd0, 8'hFF);
    program_counter(2'd0, ACC_BOTH, OPM_RATE, 16'h0003);
    program_counter(2'd1, ACC_LSB, 3'd0, 16'h0002);
    // mode 7 folds to square wave
    program_counter(2'd2, ACC_MSB, 3'd7, 16'hFF00);
    tick_run(3);
    // second latch while one is held is ignored
    latch_counter(2'd2);
    latch_counter(2'd2);
    tick_run(1);
    read_counter(2'd2);
    // read-back selector does nothing
    send_item(KIND_WRITE, CMD_PORT, 8'hFF);
    // zero reload in a periodic mode wraps through the full range
    program_counter(2'd0, ACC_BOTH, OPM_FOLD, 16'h0000);
    tick_run(2);
    read_counter(2'd0);
    read_counter(2'd0);
    wait_drained();

    next_drain = 400;
    while (sent < ITEM_TARGET) begin
      quiet = (sent >= 800 && sent < 1100);
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += 400;
      end
      pick = $urandom_range(99);
      c    = 2'($urandom_range(2));
      if (pick < 15) begin
        a = acc_t'($urandom_range(3, 1));
        m = 3'($urandom_range(7));
        v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(9, 1));
        program_counter(c, a, m, v);
      end else if (pick < 45) begin
        tick_run($urandom_range(12, 1));
      end else if (pick < 60) begin
        latch_counter(c);
        repeat ($urandom_range(2, 1)) read_counter(c);
      end else if (pick < 75) begin
        send_item(KIND_READ, 2'($urandom_range(3)), 8'($urandom));
      end else begin
        send_item(kind_t'($urandom_range(2)), 2'($urandom_range(3)), 8'($urandom));
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("interval_timer_counters_tb OK");
    end else begin
      $display("interval_timer_counters_tb NOT OK");
    end
    $finish;
  end

endmodule

### interval_timer_counters.f
rtl/core/itc_pkg.sv
rtl/core/interval_timer_counters.sv
rtl/core/itc_checker.sv
tb/interval_timer_counters_checker.sv
tb/interval_timer_counters_tb.sv
